@@ hw/rtl/source_text_tokenizer_top_defines.svh @@
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define STT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
`define STT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer sequencing check failed");
`else
`define STT_ASSERT_IMP(lbl, ante, cons)
`define STT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/stt_pkg.sv @@
package stt_pkg;

  localparam int unsigned MAX_TOKEN = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned NUM_KW    = 7;

  localparam logic [7:0] CH_EQ  = "=";
  localparam logic [7:0] CH_DOT = ".";

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_OP    = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_STR   = 3'd3,
    MODE_IDENT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_OP      = 3'd0,
    KIND_BRACKET = 3'd1,
    KIND_SYMBOL  = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_KEYWORD = 3'd5,
    KIND_IDENT   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    EMIT_IDLE  = 2'd0,
    EMIT_LOAD  = 2'd1,
    EMIT_SHORT = 2'd2
  } emit_state_e;

  // One result item that does not come from the text buffer.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       chr;
    logic [LEN_W-1:0] len;
    logic             last;
  } item_t;

  // Work handed from the scanner to the emitter for one accepted input.
  typedef struct packed {
    logic             valid;
    logic             buf_en;
    kind_e            buf_kind;
    logic [LEN_W-1:0] buf_len;
    logic             buf_trunc;
    logic [1:0]       sh_cnt;
    item_t [1:0]      sh;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  // Keyword text, left aligned in eight bytes.
  localparam logic [63:0] KW_WORD [NUM_KW] = '{
    {"let", 40'd0}, {"if", 48'd0}, {"else", 32'd0}, {"while", 24'd0},
    {"for", 40'd0}, "function", {"return", 16'd0}
  };
  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
    6'd3, 6'd2, 6'd4, 6'd5, 6'd3, 6'd8, 6'd6
  };

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
    logic [63:0] word;
    word = KW_WORD[k];
    return word[{3'd7 - pos, 3'b000} +: 8];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "<" || c == ">" || c == CH_EQ;
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == CH_DOT || c == "," || c == ":" || c == ";" || c == "!" ||
           c == "?" || c == "&" || c == "|";
  endfunction

  function automatic logic ends_ident(input logic [7:0] c);
    return is_space(c) || is_op(c) || is_bracket(c) || is_symbol(c);
  endfunction

endpackage

@@ hw/rtl/stt_in_if.sv @@
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

@@ hw/rtl/stt_out_if.sv @@
interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] char_value;
  logic [5:0] token_length;
  logic       last_char;
  logic       truncated;

  modport source (output valid, output token_kind, output char_value,
                  output token_length, output last_char, output truncated,
                  input ready);
  modport sink (input valid, input token_kind, input char_value,
                input token_length, input last_char, input truncated,
                output ready);
endinterface

@@ hw/rtl/stt_ram.sv @@
module stt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/stt_scan.sv @@
module stt_scan #(
  parameter int unsigned MaxToken = stt_pkg::MAX_TOKEN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stt_in_if.sink           in_i,
  input  logic             emit_busy_i,
  output stt_pkg::job_t    job_o,
  output stt_pkg::ram_wr_t wr_o
);

  localparam logic [stt_pkg::LEN_W-1:0] MaxCnt = stt_pkg::LEN_W'(MaxToken);

  stt_pkg::mode_e                   mode_q, mode_d;
  logic [stt_pkg::LEN_W-1:0]        count_q, count_d;
  logic                             ovf_q, ovf_d;
  logic                             dot_q, dot_d;
  logic [7:0]                       quote_q, quote_d;
  logic [7:0]                       pend_q, pend_d;
  logic [stt_pkg::NUM_KW-1:0]       kwm_q, kwm_d;
  logic                             dw_pend_q, dw_pend_d;
  logic [7:0]                       dw_data_q, dw_data_d;

  // A byte that opens a new token while the old one is still being read
  // out is parked and written to the buffer once the read-out is over.
  assign in_i.ready = !emit_busy_i && !dw_pend_q;

  always_comb begin
    logic                      fire;
    logic                      buf_req;
    stt_pkg::kind_e            bk;
    logic                      do_start;
    logic                      app;
    logic                      app_zero;
    logic                      kw_hit;
    logic [stt_pkg::LEN_W-1:0] cnt;
    logic [1:0]                n;
    logic [7:0]                c;

    fire      = in_i.valid && in_i.ready;
    c         = in_i.char_code;
    buf_req   = 1'b0;
    bk        = stt_pkg::KIND_NUMBER;
    do_start  = 1'b0;
    app       = 1'b0;
    app_zero  = 1'b0;
    kw_hit    = 1'b0;
    cnt       = count_q;
    n         = 2'd0;

    mode_d    = mode_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    dot_d     = dot_q;
    quote_d   = quote_q;
    pend_d    = pend_q;
    kwm_d     = kwm_q;
    dw_pend_d = dw_pend_q;
    dw_data_d = dw_data_q;
    job_o     = '0;
    wr_o      = '0;

    if (dw_pend_q && !emit_busy_i) begin
      wr_o      = '{en: 1'b1, addr: '0, data: dw_data_q};
      dw_pend_d = 1'b0;
    end

    if (fire) begin
      job_o.valid = 1'b1;
      if (in_i.func) begin
        unique case (mode_q)
          stt_pkg::MODE_OP: begin
            job_o.sh[n[0]] = '{kind: stt_pkg::is_op(pend_q) ? stt_pkg::KIND_OP
                                                             : stt_pkg::KIND_SYMBOL,
                               chr: pend_q, len: 6'd1, last: 1'b1};
            n = n + 2'd1;
          end
          stt_pkg::MODE_NUM: begin
            buf_req = 1'b1;
            bk      = stt_pkg::KIND_NUMBER;
          end
          stt_pkg::MODE_STR: begin
            buf_req = 1'b1;
            bk      = stt_pkg::KIND_STRING;
          end
          stt_pkg::MODE_IDENT: begin
            buf_req = 1'b1;
            bk      = stt_pkg::KIND_IDENT;
          end
          default: begin
          end
        endcase
      end else begin
        unique case (mode_q)
          stt_pkg::MODE_OP: begin
            if (((stt_pkg::is_op(pend_q) || pend_q == "!") && c == stt_pkg::CH_EQ) ||
                ((pend_q == "&" || pend_q == "|") && c == pend_q)) begin
              job_o.sh[0] = '{kind: stt_pkg::KIND_OP, chr: pend_q, len: 6'd2, last: 1'b0};
              job_o.sh[1] = '{kind: stt_pkg::KIND_OP, chr: c, len: 6'd2, last: 1'b1};
              n      = 2'd2;
              mode_d = stt_pkg::MODE_IDLE;
            end else begin
              job_o.sh[n[0]] = '{kind: stt_pkg::is_op(pend_q) ? stt_pkg::KIND_OP
                                                               : stt_pkg::KIND_SYMBOL,
                                 chr: pend_q, len: 6'd1, last: 1'b1};
              n        = n + 2'd1;
              do_start = 1'b1;
            end
            pend_d = '0;
          end
          stt_pkg::MODE_NUM: begin
            if (stt_pkg::is_digit(c)) begin
              app = 1'b1;
            end else if (c == stt_pkg::CH_DOT && !dot_q) begin
              app   = 1'b1;
              dot_d = 1'b1;
            end else begin
              buf_req  = 1'b1;
              bk       = stt_pkg::KIND_NUMBER;
              do_start = 1'b1;
            end
          end
          stt_pkg::MODE_STR: begin
            if (c == quote_q) begin
              buf_req = 1'b1;
              bk      = stt_pkg::KIND_STRING;
            end else begin
              app = 1'b1;
            end
          end
          stt_pkg::MODE_IDENT: begin
            if (stt_pkg::ends_ident(c)) begin
              buf_req  = 1'b1;
              bk       = stt_pkg::KIND_IDENT;
              do_start = 1'b1;
            end else begin
              app = 1'b1;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase
      end

      if (buf_req) begin
        for (int unsigned k = 0; k < stt_pkg::NUM_KW; k++) begin
          kw_hit = kw_hit || (kwm_q[k] && count_q == stt_pkg::KW_LEN[k]);
        end
        if (bk == stt_pkg::KIND_IDENT && !ovf_q && kw_hit) begin
          bk = stt_pkg::KIND_KEYWORD;
        end
        if (count_q == '0) begin
          // An empty string still produces one item.
          job_o.sh[n[0]] = '{kind: bk, chr: 8'd0, len: '0, last: 1'b1};
          n = n + 2'd1;
        end else begin
          job_o.buf_en    = 1'b1;
          job_o.buf_kind  = bk;
          job_o.buf_len   = count_q;
          job_o.buf_trunc = ovf_q;
        end
        count_d = '0;
        ovf_d   = 1'b0;
        dot_d   = 1'b0;
        quote_d = '0;
        mode_d  = stt_pkg::MODE_IDLE;
      end

      if (do_start) begin
        count_d = '0;
        ovf_d   = 1'b0;
        dot_d   = 1'b0;
        mode_d  = stt_pkg::MODE_IDLE;
        priority if (stt_pkg::is_space(c)) begin
          mode_d = stt_pkg::MODE_IDLE;
        end else if (stt_pkg::is_op(c) || c == "!" || c == "&" || c == "|") begin
          pend_d = c;
          mode_d = stt_pkg::MODE_OP;
        end else if (stt_pkg::is_bracket(c)) begin
          job_o.sh[n[0]] = '{kind: stt_pkg::KIND_BRACKET, chr: c, len: 6'd1, last: 1'b1};
          n = n + 2'd1;
        end else if (stt_pkg::is_symbol(c)) begin
          job_o.sh[n[0]] = '{kind: stt_pkg::KIND_SYMBOL, chr: c, len: 6'd1, last: 1'b1};
          n = n + 2'd1;
        end else if (stt_pkg::is_digit(c)) begin
          app      = 1'b1;
          app_zero = 1'b1;
          mode_d   = stt_pkg::MODE_NUM;
        end else if (c == "\"" || c == "'") begin
          quote_d = c;
          mode_d  = stt_pkg::MODE_STR;
        end else begin
          app      = 1'b1;
          app_zero = 1'b1;
          mode_d   = stt_pkg::MODE_IDENT;
        end
      end

      if (app) begin
        cnt = app_zero ? '0 : count_q;
        if (cnt < MaxCnt) begin
          if (job_o.buf_en) begin
            dw_pend_d = 1'b1;
            dw_data_d = c;
          end else begin
            wr_o = '{en: 1'b1, addr: cnt, data: c};
          end
          count_d = cnt + 6'd1;
          // Keyword candidates are narrowed byte by byte as text arrives.
          for (int unsigned k = 0; k < stt_pkg::NUM_KW; k++) begin
            kwm_d[k] = (app_zero || kwm_q[k]) && cnt < stt_pkg::KW_LEN[k] &&
                       c == stt_pkg::kw_char(k, cnt[2:0]);
          end
        end else begin
          ovf_d = 1'b1;
        end
      end

      job_o.sh_cnt = n;

      if (in_i.func) begin
        mode_d  = stt_pkg::MODE_IDLE;
        count_d = '0;
        ovf_d   = 1'b0;
        dot_d   = 1'b0;
        quote_d = '0;
        pend_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stt_pkg::MODE_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      dot_q     <= 1'b0;
      quote_q   <= '0;
      pend_q    <= '0;
      kwm_q     <= '0;
      dw_pend_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      dot_q     <= dot_d;
      quote_q   <= quote_d;
      pend_q    <= pend_d;
      kwm_q     <= kwm_d;
      dw_pend_q <= dw_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw_data_q <= dw_data_d;
  end

endmodule

@@ hw/rtl/stt_emit.sv @@
module stt_emit #(
  parameter int unsigned MaxToken = stt_pkg::MAX_TOKEN,
  localparam int unsigned AddrW = $clog2(MaxToken)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::job_t    job_i,
  input  logic [7:0]       rdata_i,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  output logic             busy_o,
  stt_out_if.source        out_o
);

  stt_pkg::emit_state_e        state_q, state_d;
  stt_pkg::job_t               job_q, job_d;
  logic [stt_pkg::LEN_W-1:0]   idx_q, idx_d;
  logic                        shi_q, shi_d;

  logic                        out_valid_q, out_valid_d;
  stt_pkg::kind_e              kind_q, kind_d;
  logic [7:0]                  chr_q, chr_d;
  logic [stt_pkg::LEN_W-1:0]   len_q, len_d;
  logic                        last_q, last_d;
  logic                        trunc_q, trunc_d;

  logic                        out_free;
  logic [stt_pkg::LEN_W-1:0]   idx_inc;

  assign out_free = !out_valid_q || out_o.ready;
  assign idx_inc  = idx_q + 6'd1;
  assign busy_o   = state_q != stt_pkg::EMIT_IDLE;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    shi_d       = shi_q;
    re_o        = 1'b0;
    raddr_o     = idx_q[AddrW-1:0];
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    chr_d       = chr_q;
    len_d       = len_q;
    last_d      = last_q;
    trunc_d     = trunc_q;

    unique case (state_q)
      stt_pkg::EMIT_IDLE: begin
        if (job_i.valid) begin
          job_d = job_i;
          idx_d = '0;
          shi_d = 1'b0;
          if (job_i.buf_en) begin
            // The first buffer byte is fetched while the transaction lands.
            re_o    = 1'b1;
            raddr_o = '0;
            state_d = stt_pkg::EMIT_LOAD;
          end else if (job_i.sh_cnt != 2'd0) begin
            state_d = stt_pkg::EMIT_SHORT;
          end
        end
      end
      stt_pkg::EMIT_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = job_q.buf_kind;
          chr_d       = rdata_i;
          len_d       = job_q.buf_len;
          last_d      = idx_inc == job_q.buf_len;
          trunc_d     = job_q.buf_trunc;
          if (idx_inc == job_q.buf_len) begin
            state_d = (job_q.sh_cnt != 2'd0) ? stt_pkg::EMIT_SHORT : stt_pkg::EMIT_IDLE;
          end else begin
            idx_d   = idx_inc;
            re_o    = 1'b1;
            raddr_o = idx_inc[AddrW-1:0];
          end
        end
      end
      stt_pkg::EMIT_SHORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = job_q.sh[shi_q].kind;
          chr_d       = job_q.sh[shi_q].chr;
          len_d       = job_q.sh[shi_q].len;
          last_d      = job_q.sh[shi_q].last;
          trunc_d     = 1'b0;
          if ({1'b0, shi_q} + 2'd1 == job_q.sh_cnt) begin
            state_d = stt_pkg::EMIT_IDLE;
          end else begin
            shi_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = stt_pkg::EMIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stt_pkg::EMIT_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    idx_q   <= idx_d;
    shi_q   <= shi_d;
    kind_q  <= kind_d;
    chr_q   <= chr_d;
    len_q   <= len_d;
    last_q  <= last_d;
    trunc_q <= trunc_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.token_kind   = kind_q;
  assign out_o.char_value   = chr_q;
  assign out_o.token_length = len_q;
  assign out_o.last_char    = last_q;
  assign out_o.truncated    = trunc_q;

endmodule

@@ hw/rtl/source_text_tokenizer_top.sv @@
// Each accepted byte hands one job to the emitter, which registers it and then loads its
// first result item into the output register; the rest of the run follows at one item per
// cycle while the sink holds ready high. No new byte is taken while a job drains, as one job
// at a time drains through a single output register, nor while a byte that ends a buffered
// token and also opens a number or an identifier waits for its first byte to go to the memory.
// Reset is asynchronous and active low; the block idles with no token pending.
`include "source_text_tokenizer_top_defines.svh"

module source_text_tokenizer_top #(
  parameter int unsigned MaxToken = stt_pkg::MAX_TOKEN
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MaxToken);
  localparam logic [stt_pkg::LEN_W-1:0] MaxLen = stt_pkg::LEN_W'(MaxToken);

  stt_pkg::job_t    job;
  stt_pkg::ram_wr_t ram_wr;
  logic             emit_busy;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  stt_scan #(
    .MaxToken(MaxToken)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .emit_busy_i (emit_busy),
    .job_o       (job),
    .wr_o        (ram_wr)
  );

  stt_ram #(
    .Width(8),
    .Depth(MaxToken)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr[AddrW-1:0]),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stt_emit #(
    .MaxToken(MaxToken)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job),
    .rdata_i (ram_rdata),
    .re_o    (ram_re),
    .raddr_o (ram_raddr),
    .busy_o  (emit_busy),
    .out_o   (out_o)
  );

  // The text memory is never written while a token is being read out of it.
  `STT_ASSERT_IMP(a_no_write_during_readout, ram_wr.en, !emit_busy)
  `STT_ASSERT_IMP(a_trunc_full_len, out_o.valid && out_o.truncated, out_o.token_length == MaxLen)
  `STT_ASSERT_IMP(a_empty_is_zero, out_o.valid && out_o.token_length == '0, out_o.char_value == 8'd0 && out_o.last_char)
  `STT_ASSERT_NXT(a_buffer_job_busy, job.valid && job.buf_en, emit_busy)

endmodule

@@ verif/testbench.sv @@
module testbench;
  import stt_pkg::*;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       chr;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             cut;
  } tok_item_t;

  // One input transaction, with up to two results typed in by hand.
  // A negative n_typed leaves the expected results to the predictor.
  typedef struct {
    bit         func;
    logic [7:0] code;
    int         n_typed;
    tok_item_t  a;
    tok_item_t  b;
  } plan_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_bus ();
  stt_out_if out_bus ();

  source_text_tokenizer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predictor state.
  mode_e      scan_st;
  logic [7:0] tok_text [MAX_TOKEN];
  int         tok_count;
  bit         tok_cut;
  bit         num_dot;
  logic [7:0] quote_ch;
  logic [7:0] held_op;

  string kw_words [7] = '{"let", "if", "else", "while", "for", "function", "return"};

  tok_item_t fresh_items [$];
  tok_item_t pending_chars [$];
  plan_t     script [$];
  plan_t     stim [$];
  plan_t     cur_plan;
  tok_item_t got;
  tok_item_t want;
  int        err_count;
  bit        gaps_on;
  int        stall_left;

  localparam tok_item_t NONE = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit blank_byte(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit op_byte(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "<" || c == ">" || c == CH_EQ;
  endfunction

  function automatic bit bracket_byte(logic [7:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  function automatic bit symbol_byte(logic [7:0] c);
    return c == CH_DOT || c == "," || c == ":" || c == ";" || c == "!" ||
           c == "?" || c == "&" || c == "|";
  endfunction

  function automatic bit breaks_word(logic [7:0] c);
    return blank_byte(c) || op_byte(c) || bracket_byte(c) || symbol_byte(c);
  endfunction

  function automatic tok_item_t mk(kind_e k, logic [7:0] ch, int len, bit last, bit cut);
    tok_item_t t;
    t.kind = k;
    t.chr  = ch;
    t.len  = LEN_W'(len);
    t.last = last;
    t.cut  = cut;
    return t;
  endfunction

  function automatic void push_short(kind_e k, logic [7:0] a, logic [7:0] b, int len);
    fresh_items = {fresh_items, mk(k, a, len, len == 1, 1'b0)};
    if (len == 2) fresh_items = {fresh_items, mk(k, b, len, 1'b1, 1'b0)};
  endfunction

  function automatic void add_byte(logic [7:0] c);
    if (tok_count < MAX_TOKEN) begin
      tok_text[tok_count] = c;
      tok_count++;
    end else begin
      tok_cut = 1'b1;
    end
  endfunction

  function automatic void clear_state();
    scan_st   = MODE_IDLE;
    tok_count = 0;
    tok_cut   = 1'b0;
    num_dot   = 1'b0;
    quote_ch  = 8'h00;
    held_op   = 8'h00;
  endfunction

  function automatic void emit_text(kind_e k);
    kind_e kk;
    bit    same;
    kk = k;
    if (kk == KIND_IDENT && !tok_cut) begin
      for (int i = 0; i < 7; i++) begin
        if (kw_words[i].len() == tok_count) begin
          same = 1'b1;
          for (int j = 0; j < tok_count; j++)
            if (kw_words[i][j] != tok_text[j]) same = 1'b0;
          if (same) kk = KIND_KEYWORD;
        end
      end
    end
    if (tok_count == 0) begin
      fresh_items = {fresh_items, mk(kk, 8'h00, 0, 1'b1, tok_cut)};
    end else begin
      for (int i = 0; i < tok_count; i++)
        fresh_items = {fresh_items,
                       mk(kk, tok_text[i], tok_count, i + 1 == tok_count, tok_cut)};
    end
    tok_count = 0;
    tok_cut   = 1'b0;
    num_dot   = 1'b0;
    quote_ch  = 8'h00;
    scan_st   = MODE_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] c);
    tok_count = 0;
    tok_cut   = 1'b0;
    num_dot   = 1'b0;
    scan_st   = MODE_IDLE;
    if (blank_byte(c)) return;
    if (op_byte(c) || c == "!" || c == "&" || c == "|") begin
      held_op = c;
      scan_st = MODE_OP;
    end else if (bracket_byte(c)) begin
      push_short(KIND_BRACKET, c, 8'h00, 1);
    end else if (symbol_byte(c)) begin
      push_short(KIND_SYMBOL, c, 8'h00, 1);
    end else if (digit_byte(c)) begin
      add_byte(c);
      scan_st = MODE_NUM;
    end else if (c == 8'h22 || c == 8'h27) begin
      quote_ch = c;
      scan_st  = MODE_STR;
    end else begin
      add_byte(c);
      scan_st = MODE_IDENT;
    end
  endfunction

  function automatic void flush_op();
    push_short(op_byte(held_op) ? KIND_OP : KIND_SYMBOL, held_op, 8'h00, 1);
    held_op = 8'h00;
    scan_st = MODE_IDLE;
  endfunction

  function automatic void scan_byte(bit f, logic [7:0] c);
    if (f) begin
      case (scan_st)
        MODE_OP:    flush_op();
        MODE_NUM:   emit_text(KIND_NUMBER);
        MODE_STR:   emit_text(KIND_STRING);
        MODE_IDENT: emit_text(KIND_IDENT);
        default:    ;
      endcase
      clear_state();
      return;
    end
    case (scan_st)
      MODE_OP: begin
        if ((op_byte(held_op) || held_op == "!") && c == CH_EQ) begin
          push_short(KIND_OP, held_op, c, 2);
          held_op = 8'h00;
          scan_st = MODE_IDLE;
        end else if ((held_op == "&" || held_op == "|") && c == held_op) begin
          push_short(KIND_OP, held_op, c, 2);
          held_op = 8'h00;
          scan_st = MODE_IDLE;
        end else begin
          flush_op();
          open_token(c);
        end
      end
      MODE_NUM: begin
        if (digit_byte(c)) begin
          add_byte(c);
        end else if (c == CH_DOT && !num_dot) begin
          add_byte(c);
          num_dot = 1'b1;
        end else begin
          emit_text(KIND_NUMBER);
          open_token(c);
        end
      end
      MODE_STR: begin
        if (c == quote_ch) emit_text(KIND_STRING);
        else add_byte(c);
      end
      MODE_IDENT: begin
        if (breaks_word(c)) begin
          emit_text(KIND_IDENT);
          open_token(c);
        end else begin
          add_byte(c);
        end
      end
      default: open_token(c);
    endcase
  endfunction

  function automatic void row(bit f, logic [7:0] code, int n, tok_item_t a, tok_item_t b);
    plan_t p;
    p.func    = f;
    p.code    = code;
    p.n_typed = n;
    p.a       = a;
    p.b       = b;
    script = {script, p};
  endfunction

  function automatic void add_stim(bit f, logic [7:0] code);
    plan_t p;
    p.func    = f;
    p.code    = code;
    p.n_typed = -1;
    p.a       = NONE;
    p.b       = NONE;
    stim = {stim, p};
  endfunction

  function automatic logic [7:0] word_byte(bit first);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'h61 + 8'($urandom_range(0, 25));
    if (sel == 6) return 8'h41 + 8'($urandom_range(0, 25));
    if (sel == 7) return "_";
    if (sel == 8 && !first) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'h80 + 8'($urandom_range(0, 127));
  endfunction

  function automatic int pick_len(int lo, int hi);
    if ($urandom_range(0, 19) == 0) return $urandom_range(30, 40);
    return $urandom_range(lo, hi);
  endfunction

  // Appends one random token, usually well formed, with an optional separator.
  function automatic void gen_token();
    int           sel;
    int           len;
    int           k;
    logic [7:0]   q;
    logic [7:0]   c;
    logic [7:0]   ops [8];
    logic [7:0]   seps [4];
    logic [7:0]   marks [14];
    ops   = '{"+", "-", "*", "/", "%", "<", ">", "="};
    seps  = '{" ", 8'h09, 8'h0D, 8'h0A};
    marks = '{"(", ")", "[", "]", "{", "}", ".", ",", ":", ";", "!", "?", "&", "|"};
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      if ($urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, 6);
        for (int i = 0; i < kw_words[k].len(); i++) add_stim(1'b0, kw_words[k][i]);
      end else begin
        len = pick_len(1, 6);
        for (int i = 0; i < len; i++) add_stim(1'b0, word_byte(i == 0));
      end
    end else if (sel < 40) begin
      len = pick_len(1, 6);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 5) == 0) add_stim(1'b0, CH_DOT);
        else add_stim(1'b0, 8'h30 + 8'($urandom_range(0, 9)));
      end
    end else if (sel < 53) begin
      q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
      add_stim(1'b0, q);
      len = pick_len(0, 8);
      for (int i = 0; i < len; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == q) c = c ^ 8'h01;
        add_stim(1'b0, c);
      end
      if ($urandom_range(0, 9) != 0) add_stim(1'b0, q);
    end else if (sel < 71) begin
      k = $urandom_range(0, 5);
      if (k < 3) begin
        add_stim(1'b0, ops[$urandom_range(0, 7)]);
        add_stim(1'b0, CH_EQ);
      end else if (k == 3) begin
        add_stim(1'b0, "!");
        add_stim(1'b0, CH_EQ);
      end else if (k == 4) begin
        c = $urandom_range(0, 1) ? "&" : "|";
        add_stim(1'b0, c);
        add_stim(1'b0, c);
      end else begin
        add_stim(1'b0, ops[$urandom_range(0, 7)]);
      end
    end else if (sel < 81) begin
      add_stim(1'b0, marks[$urandom_range(0, 13)]);
    end else if (sel < 86) begin
      add_stim(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      add_stim(1'b0, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) add_stim(1'b0, seps[$urandom_range(0, 3)]);
  endfunction

  task automatic send_one(plan_t p);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    cur_plan = p;
    in_bus.valid     <= 1'b1;
    in_bus.func      <= p.func;
    in_bus.char_code <= p.code;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_pause();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  // Sink side: ready drops in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 6);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        fresh_items.delete();
        scan_byte(in_bus.func, in_bus.char_code);
        if (cur_plan.n_typed < 0) begin
          pending_chars = {pending_chars, fresh_items};
        end else begin
          if (cur_plan.n_typed > 0) pending_chars = {pending_chars, cur_plan.a};
          if (cur_plan.n_typed > 1) pending_chars = {pending_chars, cur_plan.b};
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        got.kind = kind_e'(out_bus.token_kind);
        got.chr  = out_bus.char_value;
        got.len  = out_bus.token_length;
        got.last = out_bus.last_char;
        got.cut  = out_bus.truncated;
        if (pending_chars.size() == 0) begin
          $display({"%0t: token item with nothing expected: ",
                    "kind %0d char %02h len %0d last %0b trunc %0b"},
                   $time, got.kind, got.chr, got.len, got.last, got.cut);
          err_count++;
        end else begin
          want = pending_chars.pop_front();
          if (got !== want) begin
            $display({"%0t: token item mismatch: expected ",
                      "kind %0d char %02h len %0d last %0b trunc %0b"},
                     $time, want.kind, want.chr, want.len, want.last, want.cut);
            $display({"%0t:                      actual ",
                      "kind %0d char %02h len %0d last %0b trunc %0b"},
                     $time, got.kind, got.chr, got.len, got.last, got.cut);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.func      = 1'b0;
    in_bus.char_code = 8'h00;
    out_bus.ready    = 1'b0;
    stall_left       = 0;
    err_count        = 0;
    gaps_on          = 1'b1;
    clear_state();
    cur_plan.n_typed = -1;

    // Directed transactions: single-byte tokens, two-byte operators, the lone
    // symbol forms, a second dot, an empty string and flushes in the idle, string and operator modes.
    row(1'b0, "(",   1, mk(KIND_BRACKET, "(", 1, 1, 0), NONE);
    row(1'b0, "}",   1, mk(KIND_BRACKET, "}", 1, 1, 0), NONE);
    row(1'b0, ";",   1, mk(KIND_SYMBOL, ";", 1, 1, 0), NONE);
    row(1'b1, 8'hFF, 0, NONE, NONE);
    row(1'b0, "!",   0, NONE, NONE);
    row(1'b0, "=",   2, mk(KIND_OP, "!", 2, 0, 0), mk(KIND_OP, "=", 2, 1, 0));
    row(1'b0, "&",   0, NONE, NONE);
    row(1'b0, "&",   2, mk(KIND_OP, "&", 2, 0, 0), mk(KIND_OP, "&", 2, 1, 0));
    row(1'b0, "|",   0, NONE, NONE);
    row(1'b0, "x",   1, mk(KIND_SYMBOL, "|", 1, 1, 0), NONE);
    row(1'b0, 8'hFF, 0, NONE, NONE);
    row(1'b0, 8'h00, 0, NONE, NONE);
    row(1'b0, 8'h09, -1, NONE, NONE);
    row(1'b0, "1",   -1, NONE, NONE);
    row(1'b0, ".",   -1, NONE, NONE);
    row(1'b0, "5",   -1, NONE, NONE);
    row(1'b0, ".",   -1, NONE, NONE);
    row(1'b0, 8'h22, 0, NONE, NONE);
    row(1'b0, 8'h22, 1, mk(KIND_STRING, 8'h00, 0, 1, 0), NONE);
    row(1'b0, "i",   -1, NONE, NONE);
    row(1'b0, "f",   -1, NONE, NONE);
    row(1'b0, " ",   -1, NONE, NONE);
    row(1'b0, 8'h27, -1, NONE, NONE);
    row(1'b0, "a",   -1, NONE, NONE);
    row(1'b1, 8'h00, -1, NONE, NONE);
    row(1'b0, "<",   0, NONE, NONE);
    row(1'b1, 8'h00, 1, mk(KIND_OP, "<", 1, 1, 0), NONE);

    while (stim.size() < 390) gen_token();
    add_stim(1'b1, 8'h00);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) send_one(script[i]);
    drain_pause();

    foreach (stim[i]) begin
      // A stretch without idling in the middle, and none at the end.
      gaps_on = !((i >= 120 && i < 180) || i + 60 >= stim.size());
      if (i == 220) drain_pause();
      send_one(stim[i]);
    end
    in_bus.valid <= 1'b0;
    gaps_on = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
